@@ rtl/bba_pkg.sv @@
package bba_pkg;

  // operation codes
  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;
  localparam logic [1:0] OP_MARK  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // register indexes
  localparam logic [1:0] REG_BASE   = 2'd0;
  localparam logic [1:0] REG_BSIZE  = 2'd1;
  localparam logic [1:0] REG_BCOUNT = 2'd2;
  localparam logic [1:0] REG_RSVD   = 2'd3;

  localparam logic [31:0] BASE_RST   = 32'd0;
  localparam logic [16:0] BSIZE_RST  = 17'd4096;
  localparam logic [10:0] BCOUNT_RST = 11'd1024;
  localparam logic [10:0] RSVD_RST   = 11'd0;

  localparam logic [7:0] RESERVED_OWNER = 8'd5;

  localparam int BS_W  = 17;  // block size width
  localparam int DIV_W = 34;  // divider dividend width

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] address;
    logic [31:0] size_bytes;
    logic [4:0]  align_bits;
    logic [7:0]  mark_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] result_address;
    logic [10:0] used_count;
  } rsp_t;

  typedef struct packed {
    logic [31:0] base_address;
    logic [16:0] block_size;
    logic [10:0] block_count;
    logic [10:0] reserved_blocks;
  } cfg_t;

  // id differing from zero and from both neighbors
  function automatic logic [7:0] fresh_id(input logic [7:0] left, input logic [7:0] right);
    logic [7:0] c;
    c = left + 8'd1;
    for (int k = 0; k < 3; k++) begin
      if (c == right || c == 8'd0) begin
        c = c + 8'd1;
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/bba_if.sv @@
interface bba_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/bba_map_mem.sv @@
module bba_map_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/bba_div.sv @@
module bba_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [bba_pkg::DIV_W-1:0] dividend,
  input  logic [bba_pkg::BS_W-1:0]  divisor,
  output logic                     done,
  output logic [bba_pkg::DIV_W-1:0] quotient
);
  import bba_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [BS_W-1:0]  rem_r;
  logic [DIV_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [BS_W:0]    shifted;
  logic [BS_W:0]    diff;

  // restoring, one quotient bit a cycle
  assign shifted = {rem_r, quo_r[DIV_W-1]};
  assign diff    = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r  <= dividend;
        rem_r  <= '0;
        cnt_r  <= CNT_W'(DIV_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (shifted >= {1'b0, divisor}) begin
          rem_r <= diff[BS_W-1:0];
          quo_r <= {quo_r[DIV_W-2:0], 1'b1};
        end else begin
          rem_r <= shifted[BS_W-1:0];
          quo_r <= {quo_r[DIV_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ rtl/bba_regs.sv @@
module bba_regs (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output bba_pkg::cfg_t  cfg
);
  import bba_pkg::*;

  cfg_t       cfg_r;
  logic [1:0] idx;

  assign idx    = paddr[3:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_address    <= BASE_RST;
      cfg_r.block_size      <= BSIZE_RST;
      cfg_r.block_count     <= BCOUNT_RST;
      cfg_r.reserved_blocks <= RSVD_RST;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_BASE:   cfg_r.base_address    <= pwdata;
        REG_BSIZE:  cfg_r.block_size      <= pwdata[16:0];
        REG_BCOUNT: cfg_r.block_count     <= pwdata[10:0];
        REG_RSVD:   cfg_r.reserved_blocks <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BASE:   prdata = cfg_r.base_address;
      REG_BSIZE:  prdata = {15'd0, cfg_r.block_size};
      REG_BCOUNT: prdata = {21'd0, cfg_r.block_count};
      REG_RSVD:   prdata = {21'd0, cfg_r.reserved_blocks};
      default:    prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/bitmap_block_allocator_top.sv @@
// Next-fit block allocator over one region of equal blocks, keeping one owner byte per block in
// an on-chip map (zero = free). One request at a time yields one response. After reset the map
// is cleared by a pass over all MAP_DEPTH entries during which no request is taken (register
// writes are taken as ever). Init sweeps the whole map. Alloc first checks that the request fits
// the free bytes, takes one division for the block count, then scans the map block by block from
// each start candidate, fetches both neighbors and picks the id, then writes its blocks. An
// in-range free or mark takes one or two divisions, then reads and writes each block touched
// (free adds one closing read when its run ends before the last block). The response sits in
// an output register, loaded in S_DONE after the last map access.
module bitmap_block_allocator_top #(
  parameter int MAP_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  bba_if.sink         in_req,
  bba_if.source       out_rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bba_pkg::*;

  localparam int IW    = $clog2(MAP_DEPTH);      // map index
  localparam int CW    = $clog2(MAP_DEPTH + 1);  // block count
  localparam int CMPW  = (CW > 11) ? CW : 11;
  localparam int RGW   = CW + BS_W;              // region bytes
  localparam int RW    = ((RGW > 32) ? RGW : 32) + 1;
  localparam int PW    = IW + BS_W;
  localparam int RST_N = (1024 > MAP_DEPTH) ? MAP_DEPTH : 1024;
  localparam logic [IW-1:0] LF_RST = IW'(RST_N - 1);

  typedef enum logic [20:0] {
    S_CLEAR   = 21'h000001,
    S_IDLE    = 21'h000002,
    S_PRE     = 21'h000004,
    S_DISP    = 21'h000008,
    S_A_PRE   = 21'h000010,
    S_A_AFF   = 21'h000020,
    S_DIV     = 21'h000040,
    S_A_CAND  = 21'h000080,
    S_A_ALIGN = 21'h000100,
    S_A_RUN   = 21'h000200,
    S_A_TEST  = 21'h000400,
    S_A_LEFT  = 21'h000800,
    S_A_RIGHT = 21'h001000,
    S_A_ID    = 21'h002000,
    S_A_WR    = 21'h004000,
    S_F_RD    = 21'h008000,
    S_F_CHK   = 21'h010000,
    S_M_RD    = 21'h020000,
    S_M_WR    = 21'h040000,
    S_INIT    = 21'h080000,
    S_DONE    = 21'h100000
  } state_t;

  typedef enum logic [1:0] {
    DV_NEED,
    DV_FREE,
    DV_MARK_BI,
    DV_MARK_EI
  } div_sel_t;

  // used count follows blocks changing between zero and nonzero
  function automatic logic [CW-1:0] used_upd(input logic [CW-1:0] u, input logic [7:0] old,
                                             input logic [7:0] v);
    logic [CW-1:0] r;
    r = u;
    if (old == 8'd0 && v != 8'd0) begin
      r = u + CW'(1);
    end else if (old != 8'd0 && v == 8'd0 && u != '0) begin
      r = u - CW'(1);
    end
    return r;
  endfunction

  cfg_t cfg;

  bba_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  state_t           state_r;
  req_t             req_r;
  logic [CW-1:0]    rr_r;
  logic [RGW-1:0]   region_r;
  logic [RGW-1:0]   ubytes_r;
  logic [CW-1:0]    need_r;
  logic [IW-1:0]    x_r;
  logic [CW:0]      cnt_r;
  logic [CW-1:0]    y_r;
  logic [PW-1:0]    prod_r;
  logic [31:0]      a_r;
  logic [7:0]       left_r;
  logic [7:0]       id_r;
  logic [CW-1:0]    i_r;
  logic [CW-1:0]    ei_r;
  logic             first_r;
  logic [IW-1:0]    last_found_r;
  logic [CW-1:0]    used_r;
  logic [1:0]       st_r;
  logic [31:0]      res_r;
  div_sel_t         div_sel_r;
  logic             div_go_r;
  logic [DIV_W-1:0] div_dvd_r;
  logic             out_valid_r;
  rsp_t             out_data_r;

  // effective register values
  logic [CMPW-1:0] bc_ext, rs_ext;
  logic [CW-1:0]   n_c, r_c;
  logic [BS_W-1:0] bs_c;

  always_comb begin
    bc_ext = CMPW'(cfg.block_count);
    rs_ext = CMPW'(cfg.reserved_blocks);
    if (bc_ext == '0) begin
      n_c = CW'(1);
    end else if (bc_ext > CMPW'(MAP_DEPTH)) begin
      n_c = CW'(MAP_DEPTH);
    end else begin
      n_c = CW'(bc_ext);
    end
    r_c  = (rs_ext > CMPW'(n_c)) ? n_c : CW'(rs_ext);
    bs_c = (cfg.block_size == '0) ? BS_W'(1) : cfg.block_size;
  end

  // region bounds and range checks
  logic [RW-1:0]  top_c;
  logic           in_rng_c, mark_ok_c, afford_c, lt_base_c;
  logic [32:0]    end_c;
  logic [31:0]    mask_c, a_c;
  logic [CW:0]    xy_c, endb_c;
  logic [IW-1:0]  start_c;
  logic [7:0]     rdata;
  logic [DIV_W-1:0] quot;
  logic           div_done;
  logic           match_c;

  assign top_c     = RW'(cfg.base_address) + RW'(region_r);
  assign in_rng_c  = (RW'(req_r.address) >= RW'(cfg.base_address)) &&
                     (RW'(req_r.address) < top_c);
  assign end_c     = {1'b0, req_r.address} + {1'b0, req_r.size_bytes};
  assign lt_base_c = req_r.address < cfg.base_address;
  assign mark_ok_c = (req_r.size_bytes != 32'd0) && (end_c > {1'b0, cfg.base_address}) &&
                     (RW'(req_r.address) < top_c);
  assign afford_c  = (ubytes_r <= region_r) &&
                     (RW'(region_r - ubytes_r) >= RW'(req_r.size_bytes));
  assign mask_c    = ~(32'hFFFF_FFFF << req_r.align_bits);
  assign a_c       = cfg.base_address + 32'(prod_r);
  assign xy_c      = (CW+1)'(x_r) + (CW+1)'(y_r);
  assign endb_c    = (CW+1)'(x_r) + (CW+1)'(need_r);
  assign start_c   = ((CW'(last_found_r) + CW'(1)) >= n_c) ? '0 : last_found_r + IW'(1);
  assign match_c   = first_r ? (rdata != 8'd0) : (rdata == id_r);

  bba_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go_r),
    .dividend (div_dvd_r),
    .divisor  (bs_c),
    .done     (div_done),
    .quotient (quot)
  );

  // map port control
  logic          mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = IW'(i_r);
    mem_wdata = 8'd0;
    mem_raddr = IW'(i_r);
    case (state_r)
      S_CLEAR: mem_we = 1'b1;
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = (i_r < rr_r) ? RESERVED_OWNER : 8'd0;
      end
      S_A_RUN:   mem_raddr = IW'(xy_c);
      S_A_LEFT:  mem_raddr = x_r - IW'(1);
      S_A_RIGHT: mem_raddr = IW'(endb_c);
      S_A_WR: begin
        mem_we    = 1'b1;
        mem_wdata = id_r;
      end
      S_F_CHK: mem_we = match_c;
      S_M_WR: begin
        mem_we    = 1'b1;
        mem_wdata = req_r.mark_value;
      end
      default: ;
    endcase
  end

  bba_map_mem #(.DEPTH(MAP_DEPTH), .AW(IW)) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  logic [CW-1:0] ei_c;
  assign ei_c = (quot > DIV_W'(n_c)) ? n_c : CW'(quot);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      i_r          <= '0;
      last_found_r <= LF_RST;
      used_r       <= '0;
      div_go_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      div_go_r <= 1'b0;
      // S_DONE reloads the output register itself
      if (out_valid_r && out_rsp.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          i_r <= i_r + CW'(1);
          if (i_r == CW'(MAP_DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_req.valid) begin
            req_r   <= in_req.data;
            rr_r    <= r_c;
            st_r    <= ST_OK;
            res_r   <= 32'd0;
            i_r     <= '0;
            if (in_req.data.operation == OP_INIT) begin
              state_r <= S_INIT;
            end else if (in_req.data.operation == OP_ALLOC &&
                         in_req.data.size_bytes == 32'd0) begin
              st_r    <= ST_NOFIT;
              state_r <= S_DONE;
            end else begin
              state_r <= S_PRE;
            end
          end
        end

        S_PRE: begin
          region_r <= n_c * bs_c;
          state_r  <= S_DISP;
        end

        S_DISP: begin
          case (req_r.operation)
            OP_ALLOC: state_r <= S_A_PRE;
            OP_FREE: begin
              if (in_rng_c) begin
                div_go_r  <= 1'b1;
                div_sel_r <= DV_FREE;
                div_dvd_r <= DIV_W'(req_r.address - cfg.base_address);
                state_r   <= S_DIV;
              end else begin
                st_r    <= ST_RANGE;
                state_r <= S_DONE;
              end
            end
            default: begin
              if (mark_ok_c) begin
                div_go_r <= 1'b1;
                state_r  <= S_DIV;
                if (lt_base_c) begin
                  // range starts below the region: begin at block 0
                  i_r       <= '0;
                  div_sel_r <= DV_MARK_EI;
                  div_dvd_r <= DIV_W'(end_c) - DIV_W'(cfg.base_address) +
                               DIV_W'(bs_c) - DIV_W'(1);
                end else begin
                  div_sel_r <= DV_MARK_BI;
                  div_dvd_r <= DIV_W'(req_r.address - cfg.base_address);
                end
              end else begin
                st_r    <= ST_RANGE;
                state_r <= S_DONE;
              end
            end
          endcase
        end

        S_A_PRE: begin
          ubytes_r <= used_r * bs_c;
          state_r  <= S_A_AFF;
        end

        S_A_AFF: begin
          if (afford_c) begin
            div_go_r  <= 1'b1;
            div_sel_r <= DV_NEED;
            div_dvd_r <= DIV_W'(req_r.size_bytes) + DIV_W'(bs_c) - DIV_W'(1);
            state_r   <= S_DIV;
          end else begin
            st_r    <= ST_NOFIT;
            state_r <= S_DONE;
          end
        end

        S_DIV: begin
          if (div_done) begin
            case (div_sel_r)
              DV_NEED: begin
                if (quot > DIV_W'(n_c)) begin
                  st_r    <= ST_NOFIT;
                  state_r <= S_DONE;
                end else begin
                  need_r  <= CW'(quot);
                  x_r     <= start_c;
                  cnt_r   <= '0;
                  state_r <= S_A_CAND;
                end
              end
              DV_FREE: begin
                i_r     <= CW'(quot);
                first_r <= 1'b1;
                state_r <= S_F_RD;
              end
              DV_MARK_BI: begin
                i_r       <= CW'(quot);
                div_go_r  <= 1'b1;
                div_sel_r <= DV_MARK_EI;
                div_dvd_r <= DIV_W'(end_c) - DIV_W'(cfg.base_address) +
                             DIV_W'(bs_c) - DIV_W'(1);
              end
              default: begin
                ei_r    <= ei_c;
                state_r <= (i_r < ei_c) ? S_M_RD : S_DONE;
              end
            endcase
          end
        end

        S_A_CAND: begin
          if (cnt_r >= (CW+1)'(n_c)) begin
            st_r    <= ST_NOFIT;
            state_r <= S_DONE;
          end else begin
            prod_r  <= x_r * bs_c;
            state_r <= S_A_ALIGN;
          end
        end

        S_A_ALIGN: begin
          if ((a_c & mask_c) != 32'd0) begin
            cnt_r   <= cnt_r + (CW+1)'(1);
            x_r     <= ((CW'(x_r) + CW'(1)) == n_c) ? '0 : x_r + IW'(1);
            state_r <= S_A_CAND;
          end else begin
            a_r     <= a_c;
            y_r     <= '0;
            state_r <= S_A_RUN;
          end
        end

        S_A_RUN: begin
          if (y_r == need_r) begin
            state_r <= S_A_LEFT;
          end else if (xy_c >= (CW+1)'(n_c)) begin
            // run hits the last block: no later start before the wrap fits
            cnt_r   <= cnt_r + (CW+1)'(n_c) - (CW+1)'(x_r);
            x_r     <= '0;
            state_r <= S_A_CAND;
          end else begin
            state_r <= S_A_TEST;
          end
        end

        S_A_TEST: begin
          if (rdata == 8'd0) begin
            y_r     <= y_r + CW'(1);
            state_r <= S_A_RUN;
          end else begin
            // every start up to the used block fails too
            cnt_r   <= cnt_r + (CW+1)'(y_r) + (CW+1)'(1);
            x_r     <= ((xy_c + (CW+1)'(1)) == (CW+1)'(n_c)) ? '0 : IW'(xy_c + (CW+1)'(1));
            state_r <= S_A_CAND;
          end
        end

        S_A_LEFT: state_r <= S_A_RIGHT;

        S_A_RIGHT: begin
          left_r  <= (x_r != '0) ? rdata : 8'd0;
          state_r <= S_A_ID;
        end

        S_A_ID: begin
          id_r    <= fresh_id(left_r, (endb_c < (CW+1)'(n_c)) ? rdata : 8'd0);
          i_r     <= CW'(x_r);
          state_r <= S_A_WR;
        end

        S_A_WR: begin
          used_r <= used_upd(used_r, 8'd0, id_r);
          i_r    <= i_r + CW'(1);
          if ((CW+1)'(i_r) + (CW+1)'(1) == endb_c) begin
            last_found_r <= IW'(i_r);
            res_r        <= a_r;
            state_r      <= S_DONE;
          end
        end

        S_F_RD: state_r <= S_F_CHK;

        S_F_CHK: begin
          if (match_c) begin
            used_r  <= used_upd(used_r, rdata, 8'd0);
            id_r    <= first_r ? rdata : id_r;
            first_r <= 1'b0;
            i_r     <= i_r + CW'(1);
            state_r <= ((i_r + CW'(1)) < n_c) ? S_F_RD : S_DONE;
          end else begin
            state_r <= S_DONE;
          end
        end

        S_M_RD: state_r <= S_M_WR;

        S_M_WR: begin
          used_r  <= used_upd(used_r, rdata, req_r.mark_value);
          i_r     <= i_r + CW'(1);
          state_r <= ((i_r + CW'(1)) < ei_r) ? S_M_RD : S_DONE;
        end

        S_INIT: begin
          i_r <= i_r + CW'(1);
          if (i_r == CW'(MAP_DEPTH - 1)) begin
            last_found_r <= (rr_r != '0) ? IW'(rr_r - CW'(1)) : IW'(n_c - CW'(1));
            used_r       <= rr_r;
            state_r      <= S_DONE;
          end
        end

        S_DONE: begin
          if (!out_valid_r || out_rsp.ready) begin
            out_valid_r               <= 1'b1;
            out_data_r.status         <= st_r;
            out_data_r.result_address <= res_r;
            out_data_r.used_count     <= 11'(used_r);
            state_r                   <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_req.ready  = (state_r == S_IDLE);
  assign out_rsp.valid = out_valid_r;
  assign out_rsp.data  = out_data_r;

endmodule
